// ===== src/lzg_pkg.sv =====
// ----------------------------------------------------------------------------
// lzg_pkg
// shared types and constants of the lozenge tiling flip block
// ----------------------------------------------------------------------------
`default_nettype none

package lzg_pkg;

    // grid size
    localparam int COLS = 128;
    localparam int ROWS = 256;

    // field widths
    localparam int N_W    = 7;
    localparam int J_W    = 8;
    localparam int OP_W   = 2;
    localparam int PAIR_W = 2;
    localparam int CNT_W  = 32;

    // four banks split by column and row parity
    localparam int NUM_BANKS  = 4;
    localparam int COLH       = (COLS + 1) / 2;
    localparam int ROWH       = (ROWS + 1) / 2;
    localparam int BANK_DEPTH = COLH * ROWH;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // pairing codes
    localparam logic [PAIR_W-1:0] PAIR_NONE  = 2'd0;
    localparam logic [PAIR_W-1:0] PAIR_SAME  = 2'd1;
    localparam logic [PAIR_W-1:0] PAIR_BELOW = 2'd2;
    localparam logic [PAIR_W-1:0] PAIR_LEFT  = 2'd3;

    typedef struct packed {
        logic              black;
        logic              white;
        logic [PAIR_W-1:0] pair;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [N_W-1:0]    cell_n;
        logic [J_W-1:0]    cell_j;
        logic              coin;
        logic              black_here;
        logic              white_here;
        logic [PAIR_W-1:0] pair_code;
    } t_in_item;

    typedef struct packed {
        logic              eligible;
        logic              flipped;
        logic              read_black;
        logic              read_white;
        logic [PAIR_W-1:0] read_pair;
        logic [CNT_W-1:0]  flip_total;
    } t_out_item;

endpackage

`default_nettype wire

// ===== src/lzg_in_if.sv =====
// ----------------------------------------------------------------------------
// lzg_in_if
// input channel: valid, ready and one command item
// ----------------------------------------------------------------------------
`default_nettype none

interface lzg_in_if;
    import lzg_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lzg_out_if.sv =====
// ----------------------------------------------------------------------------
// lzg_out_if
// output channel: valid, ready and one result item
// ----------------------------------------------------------------------------
`default_nettype none

interface lzg_out_if;
    import lzg_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lzg_cell_ram.sv =====
// ----------------------------------------------------------------------------
// lzg_cell_ram
// simple dual-port ram, one write and one registered read with enable
// ----------------------------------------------------------------------------
`default_nettype none

module lzg_cell_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/lozenge_tiling_glauber_flip.sv =====
// ----------------------------------------------------------------------------
// lozenge_tiling_glauber_flip
// triangle grid with cell write/read and a hexagon flip step at a vertex
// ----------------------------------------------------------------------------
// an accepted command is held while its cells are read from the four grid banks,
//   then its result is registered in the write-back pass over the banks; no new
//   command is taken until then, and an untaken result holds the next command
//   in its write-back cycle until the output register frees up
// reset: after i_rst_n a clearing pass zeroes all BANK_DEPTH addresses of
//   every bank (8192 at 128 x 256); no command is taken before it ends
`default_nettype none

module lozenge_tiling_glauber_flip (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lzg_in_if.sink     i_in,
    lzg_out_if.source  o_out
);
    import lzg_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state               r_state;
    logic [BANK_AW-1:0]   r_clr_addr;
    logic                 r_out_valid;
    t_out_item            r_out_data;
    logic [CNT_W-1:0]     r_flip_total;

    // command held during the write-back cycle
    t_in_item             r_item;
    logic [BANK_AW-1:0]   r_waddr  [NUM_BANKS];
    logic                 r_ingrid [NUM_BANKS];

    logic                 w_accept;
    logic                 w_done;
    logic [BANK_AW-1:0]   w_raddr  [NUM_BANKS];
    logic                 w_ingrid [NUM_BANKS];
    t_cell                w_rd     [NUM_BANKS];
    logic                 w_we     [NUM_BANKS];
    t_cell                w_wdata  [NUM_BANKS];
    logic [BANK_AW-1:0]   w_ram_waddr [NUM_BANKS];

    t_out_item            n_out_data;
    logic [CNT_W-1:0]     n_flip_total;

    // ready whenever no command is in flight; an unread result does not block
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_done      = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // bank b holds cells with column parity b[0] and row parity b[1];
    // the four cells of a hexagon fall into four different banks
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic            col_same;
        logic            row_same;
        logic [N_W:0]    col;
        logic [J_W:0]    row;
        logic [N_W-1:0]  col_half;
        logic [J_W-1:0]  row_half;

        always_comb begin
            col_same = (1'(b) == i_in.data.cell_n[0]);
            row_same = (1'(b >> 1) == i_in.data.cell_j[0]);
            // column to the left when the parity differs
            col = col_same ? {1'b0, i_in.data.cell_n}
                           : {1'b0, i_in.data.cell_n} - (N_W+1)'(1);
            // row above when the parity differs
            row = row_same ? {1'b0, i_in.data.cell_j}
                           : {1'b0, i_in.data.cell_j} + (J_W+1)'(1);
            col_half = col[N_W:1];
            row_half = row[J_W:1];
            w_raddr[b] = BANK_AW'(int'(row_half) * COLH + int'(col_half));
            w_ingrid[b] = (col_same ? (int'(col) < COLS) : (i_in.data.cell_n != '0))
                          && (int'(row) < ROWS);
        end

        assign w_ram_waddr[b] = (r_state == S_CLEAR) ? r_clr_addr : r_waddr[b];

        lzg_cell_ram #(
            .DEPTH (BANK_DEPTH),
            .AW    (BANK_AW),
            .DW    (CELL_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_waddr (w_ram_waddr[b]),
            .i_wdata (w_wdata[b]),
            .i_re    (w_accept),
            .i_raddr (w_raddr[b]),
            .o_rdata (w_rd[b])
        );
    end

    // evaluate the held command on the bank read data
    always_comb begin
        logic [1:0] q_bank;
        logic [1:0] w_bank;
        logic [1:0] p_bank;
        logic [1:0] r_bank;
        t_cell      cq;
        t_cell      cw;
        t_cell      cp;
        t_cell      cr;
        logic       present;
        logic       ok;
        logic       flip;

        q_bank = {r_item.cell_j[0], r_item.cell_n[0]};      // (n, j)
        w_bank = {r_item.cell_j[0], ~r_item.cell_n[0]};     // (n-1, j)
        p_bank = {~r_item.cell_j[0], r_item.cell_n[0]};     // (n, j+1)
        r_bank = {~r_item.cell_j[0], ~r_item.cell_n[0]};    // (n-1, j+1)
        cq = w_rd[q_bank];
        cw = w_rd[w_bank];
        cp = w_rd[p_bank];
        cr = w_rd[r_bank];

        // cells outside the grid count as absent
        present = r_ingrid[q_bank] && r_ingrid[w_bank]
                  && r_ingrid[p_bank] && r_ingrid[r_bank]
                  && cp.black && cq.black && cr.black
                  && cq.white && cw.white && cr.white;
        ok = ((cp.pair == PAIR_BELOW) || (cp.pair == PAIR_LEFT))
             && ((cq.pair == PAIR_SAME) || (cq.pair == PAIR_LEFT))
             && ((cr.pair == PAIR_SAME) || (cr.pair == PAIR_BELOW));

        n_out_data   = '0;
        n_flip_total = r_flip_total;
        flip         = 1'b0;

        for (int b = 0; b < NUM_BANKS; b++) begin
            w_we[b]    = 1'b0;
            w_wdata[b] = w_rd[b];
        end

        case (r_item.opcode)
            OP_WRITE: begin
                w_we[q_bank]          = w_done && r_ingrid[q_bank];
                w_wdata[q_bank].black = r_item.black_here;
                w_wdata[q_bank].white = r_item.white_here;
                w_wdata[q_bank].pair  = r_item.pair_code;
            end
            OP_READ: begin
                if (r_ingrid[q_bank]) begin
                    n_out_data.read_black = cq.black;
                    n_out_data.read_white = cq.white;
                    n_out_data.read_pair  = cq.pair;
                end
            end
            OP_STEP: begin
                n_out_data.eligible = present && ok;
                flip                = present && ok && r_item.coin;
                n_out_data.flipped  = flip;
                // rotate the three lozenges to the other hexagon edges
                w_wdata[p_bank].pair = (cp.pair == PAIR_BELOW) ? PAIR_LEFT : PAIR_BELOW;
                w_wdata[q_bank].pair = (cq.pair == PAIR_SAME) ? PAIR_LEFT : PAIR_SAME;
                w_wdata[r_bank].pair = (cr.pair == PAIR_SAME) ? PAIR_BELOW : PAIR_SAME;
                w_we[p_bank] = w_done && flip;
                w_we[q_bank] = w_done && flip;
                w_we[r_bank] = w_done && flip;
                if (flip) begin
                    n_flip_total = r_flip_total + CNT_W'(1);
                end
            end
            default: begin
                // undefined opcode: no state change
            end
        endcase

        n_out_data.flip_total = n_flip_total;

        // clearing pass writes zero to every bank
        if (r_state == S_CLEAR) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                w_we[b]    = 1'b1;
                w_wdata[b] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_flip_total <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + BANK_AW'(1);
                    if (r_clr_addr == BANK_AW'(BANK_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase

            if (w_done) begin
                r_out_valid  <= 1'b1;
                r_flip_total <= n_flip_total;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end

        // payload registers
        if (w_done) begin
            r_out_data <= n_out_data;
        end
        if (w_accept) begin
            r_item <= i_in.data;
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_waddr[b]  <= w_raddr[b];
                r_ingrid[b] <= w_ingrid[b];
            end
        end
    end

    // no transaction is taken during the clearing pass
    a_no_accept_in_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready
    ) else $error("input taken during clearing pass");

    // a carried out rotation is always an eligible one
    a_flip_eligible: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.flipped) |-> o_out.data.eligible
    ) else $error("flip reported on ineligible hexagon");

    // the counter moves by one on a flip and holds otherwise
    a_count_step: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_done && (r_item.opcode == OP_STEP) && n_out_data.flipped)
        |=> (r_flip_total == $past(r_flip_total) + CNT_W'(1))
    ) else $error("flip counter did not advance");

    // the reported count matches the counter once a result is out
    a_total_matches: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_out_data.flip_total == r_flip_total)
    ) else $error("reported flip total differs from counter");

    // a command never completes in the same cycle it is taken
    a_one_in_flight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC)
    ) else $error("command not held for write-back");

endmodule

`default_nettype wire
